### sv/dtcf_pkg.sv
package dtcf_pkg;

  localparam int DW = 32;
  localparam int NW = 18;
  localparam int UW = 31;
  localparam int PW = 64;
  localparam int QW = 33;

  // latency of one vector norm and of one divider, input register to output register
  localparam int NORM_LAT = 34;
  localparam int DIV_LAT  = 33;

  typedef logic signed [DW-1:0] s32_t;
  typedef logic signed [NW-1:0] s18_t;
  typedef logic [UW-1:0] u31_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_SPRING  = 2'd0;
  localparam reg_idx_t REG_DAMPING = 2'd1;
  localparam reg_idx_t REG_STEP    = 2'd2;

  localparam u31_t RST_SPRING  = 31'd65536;
  localparam u31_t RST_DAMPING = 31'd0;
  localparam u31_t RST_STEP    = 31'd655;

  localparam logic signed [PW-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [PW-1:0] S32_MIN = -64'sd2147483648;

  function automatic s32_t sat32(input logic signed [PW-1:0] x);
    s32_t r;
    if (x > S32_MAX) r = 32'sh7fff_ffff;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = s32_t'(x[DW-1:0]);
    return r;
  endfunction

  function automatic logic [DW-1:0] mag32(input s32_t x);
    logic [DW-1:0] r;
    r = x[DW-1] ? (~x + 32'd1) : x;
    return r;
  endfunction

  // signed result of a capped quotient, saturated to 32 bits
  function automatic s32_t clip_q(input logic [QW-1:0] q, input logic neg);
    s32_t r;
    if (neg) begin
      if (q[QW-1:DW-1] != '0) r = 32'sh8000_0000;
      else r = s32_t'(-q[DW-1:0]);
    end else begin
      if (q >= 33'h0_7fff_ffff) r = 32'sh7fff_ffff;
      else r = s32_t'(q[DW-1:0]);
    end
    return r;
  endfunction

endpackage

### sv/dtcf_dly.sv
module dtcf_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [N];

  always_ff @(posedge clk) begin
    pipe_r[0] <= d;
    for (int i = 1; i < N; i++) pipe_r[i] <= pipe_r[i-1];
  end

  assign q = pipe_r[N-1];

endmodule

### sv/dtcf_sqrt.sv
module dtcf_sqrt #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic [W-1:0]   x,
  output logic [W/2-1:0] root
);

  localparam int N  = W / 2;
  localparam int RW = N + 2;

  logic [W-1:0]  x_r    [N];
  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];

  // one root bit per stage, radicand consumed two bits at a time from the top
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W-1:0]  x_in;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    if (s == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    assign rem_sh = {rem_in[RW-3:0], x_in[W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      x_r[s] <= x_in << 2;
      if (rem_sh >= trial) begin
        rem_r[s]  <= rem_sh - trial;
        root_r[s] <= {root_in[N-2:0], 1'b1};
      end else begin
        rem_r[s]  <= rem_sh;
        root_r[s] <= {root_in[N-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[N-1];

endmodule

### sv/dtcf_div.sv
module dtcf_div (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [32:0] quo
);

  import dtcf_pkg::*;

  localparam int S = DW;

  logic [DW-1:0] rem_r [S+1];
  logic [DW-1:0] lo_r  [S+1];
  logic [DW-1:0] den_r [S+1];
  logic [DW-1:0] q_r   [S+1];
  logic          ovf_r [S+1];

  // quotient of 2^32 or more is reported capped at 2^32
  always_ff @(posedge clk) begin
    ovf_r[0] <= num[PW-1:DW] >= den;
    rem_r[0] <= num[PW-1:DW];
    lo_r[0]  <= num[DW-1:0];
    den_r[0] <= den;
    q_r[0]   <= '0;
  end

  for (genvar s = 1; s <= S; s++) begin : g_stage
    logic [DW:0] t;
    logic        ge;
    logic [DW:0] diff;

    assign t    = {rem_r[s-1], lo_r[s-1][DW-1]};
    assign ge   = t >= {1'b0, den_r[s-1]};
    assign diff = t - {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      rem_r[s] <= ge ? diff[DW-1:0] : t[DW-1:0];
      q_r[s]   <= {q_r[s-1][DW-2:0], ge};
      lo_r[s]  <= lo_r[s-1] << 1;
      den_r[s] <= den_r[s-1];
      ovf_r[s] <= ovf_r[s-1];
    end
  end

  assign quo = ovf_r[S] ? 33'h1_0000_0000 : {1'b0, q_r[S]};

endmodule

### sv/dtcf_norm.sv
module dtcf_norm (
  input  logic               clk,
  input  dtcf_pkg::s32_t     a,
  input  dtcf_pkg::s32_t     b,
  input  dtcf_pkg::s32_t     c,
  output logic [31:0]        len
);

  import dtcf_pkg::*;

  logic [PW-1:0] sqa_r, sqb_r, sqc_r;
  logic [PW-1:0] sum_r;

  // three squares stay below 2^64 since each is at most 2^62
  always_ff @(posedge clk) begin
    sqa_r <= PW'(mag32(a)) * PW'(mag32(a));
    sqb_r <= PW'(mag32(b)) * PW'(mag32(b));
    sqc_r <= PW'(mag32(c)) * PW'(mag32(c));
    sum_r <= sqa_r + sqb_r + sqc_r;
  end

  dtcf_sqrt #(.W(PW)) u_sqrt (
    .clk  (clk),
    .x    (sum_r),
    .root (len)
  );

endmodule

### sv/dem_tangential_contact_force.sv
// Tangential spring-dashpot contact force with Coulomb friction limit.
// Input channel: drive start high for one cycle with the contact fields on
// the in_ ports; the item is taken at that clock edge. busy is always low, so
// a new item may be given in every cycle.
// Result channel: out_strobe is high for one cycle with force, new gap and
// stick flag on the out_ ports. Results leave in the order items came in, one
// per item. The receiver cannot stall. Throughput is one item per cycle; the
// result path is a chain of two vector norms (one root bit per stage) and
// three restoring dividers (one quotient bit per stage) plus arithmetic stages.
// Configuration: APB-style port, registers at byte addresses 0 (stiffness),
// 4 (damping factor) and 8 (step size). Write only while no item is in flight.
// Reset (rst_n low, synchronous) clears all in-flight items and restores the
// register defaults; no clearing pass is needed.
module dem_tangential_contact_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dtcf_pkg::s32_t       in_gap_x,
  input  dtcf_pkg::s32_t       in_gap_y,
  input  dtcf_pkg::s32_t       in_gap_z,
  input  logic                 in_stick_in,
  input  dtcf_pkg::s18_t       in_normal_x,
  input  dtcf_pkg::s18_t       in_normal_y,
  input  dtcf_pkg::s18_t       in_normal_z,
  input  dtcf_pkg::s32_t       in_vel_x,
  input  dtcf_pkg::s32_t       in_vel_y,
  input  dtcf_pkg::s32_t       in_vel_z,
  input  dtcf_pkg::u31_t       in_effective_mass,
  input  dtcf_pkg::u31_t       in_friction_times_normal,
  output logic                 out_strobe,
  output dtcf_pkg::s32_t       out_force_x,
  output dtcf_pkg::s32_t       out_force_y,
  output dtcf_pkg::s32_t       out_force_z,
  output dtcf_pkg::s32_t       out_new_gap_x,
  output dtcf_pkg::s32_t       out_new_gap_y,
  output dtcf_pkg::s32_t       out_new_gap_z,
  output logic                 out_stick_out,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  import dtcf_pkg::*;

  localparam int SQ_W   = ((UW + FRAC_BITS + 1) / 2) * 2;
  localparam int SQ_N   = SQ_W / 2;
  localparam int DM_W   = UW + SQ_N;
  localparam int T_G1   = 4;
  localparam int T_NEWL = T_G1 + NORM_LAT;
  localparam int T_SC   = T_NEWL + 1;
  localparam int T_G2   = T_SC + DIV_LAT + 1;
  localparam int T_G3   = T_G2 + 1;
  localparam int T_D    = 40;
  localparam int T_PD   = T_D + 1;
  localparam int T_F    = T_G3 + 2;
  localparam int T_FN   = T_F + NORM_LAT;
  localparam int T_FP   = T_FN + 1;
  localparam int T_F2   = T_FP + DIV_LAT + 1;
  localparam int T_NUM  = T_F2 + 1;
  localparam int T_GS   = T_NUM + DIV_LAT;
  localparam int T_OUT  = T_GS + 1;

  logic in_accept;
  logic [T_OUT:0] vld_r;

  u31_t k_r, dmp_r, dt_r;

  s32_t g0_r [3];
  s18_t n0_r [3];
  s32_t v0_r [3];
  u31_t m0_r, lim0_r;
  logic stk0_r;

  s32_t dot_r;
  logic signed [49:0] pn_r [3];

  logic [31:0] old_len, old_len_d38, new_len, fn;
  logic [31:0] den_sc_r, den_f_r;
  logic        nz_d72, stk_d73;
  logic [SQ_N-1:0] root;
  logic [DM_W-1:0] dm_r;
  logic [DM_W-1:0] dm_sh;
  u31_t d_r, d_d40, lim_d110;
  logic slip_r, slip_d144, slip145_r, slip_d179;

  s32_t g1_r [3];
  s32_t g2_r [3];
  s32_t g3_r [3];
  s32_t f_r  [3];
  s32_t f2_r [3];
  s32_t frc_r [3];
  s32_t gap_r [3];
  logic stick_r;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign in_accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r   <= RST_SPRING;
      dmp_r <= RST_DAMPING;
      dt_r  <= RST_STEP;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SPRING:  k_r   <= pwdata[UW-1:0];
        REG_DAMPING: dmp_r <= pwdata[UW-1:0];
        REG_STEP:    dt_r  <= pwdata[UW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SPRING:  prdata = {1'b0, k_r};
      REG_DAMPING: prdata = {1'b0, dmp_r};
      REG_STEP:    prdata = {1'b0, dt_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[T_OUT-1:0], in_accept};
  end

  always_ff @(posedge clk) begin
    g0_r[0] <= in_gap_x;
    g0_r[1] <= in_gap_y;
    g0_r[2] <= in_gap_z;
    n0_r[0] <= in_normal_x;
    n0_r[1] <= in_normal_y;
    n0_r[2] <= in_normal_z;
    v0_r[0] <= in_vel_x;
    v0_r[1] <= in_vel_y;
    v0_r[2] <= in_vel_z;
    m0_r    <= in_effective_mass;
    lim0_r  <= in_friction_times_normal;
    stk0_r  <= in_stick_in;
  end

  // damping coefficient d = factor * sqrt(mass)
  dtcf_sqrt #(.W(SQ_W)) u_msqrt (
    .clk  (clk),
    .x    (SQ_W'({m0_r, {FRAC_BITS{1'b0}}})),
    .root (root)
  );

  assign dm_sh = dm_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    dm_r <= DM_W'(dmp_r) * DM_W'(root);
    d_r  <= (dm_sh[DM_W-1:UW] != '0) ? 31'h7fff_ffff : dm_sh[UW-1:0];
  end

  dtcf_dly #(.W(UW), .N(T_D - SQ_N - 2)) u_d (.clk(clk), .d(d_r), .q(d_d40));

  // projection of the gap onto the contact plane
  always_ff @(posedge clk) begin
    dot_r <= sat32((PW'(pn_r[0]) + PW'(pn_r[1]) + PW'(pn_r[2])) >>> FRAC_BITS);
  end

  dtcf_norm u_old (.clk(clk), .a(g0_r[0]), .b(g0_r[1]), .c(g0_r[2]), .len(old_len));
  dtcf_dly #(.W(32), .N(T_NEWL - NORM_LAT)) u_ol (.clk(clk), .d(old_len), .q(old_len_d38));
  dtcf_norm u_new (.clk(clk), .a(g1_r[0]), .b(g1_r[1]), .c(g1_r[2]), .len(new_len));
  dtcf_dly #(.W(1), .N(DIV_LAT + 1)) u_nz (.clk(clk), .d(new_len != '0), .q(nz_d72));
  dtcf_dly #(.W(1), .N(T_G2)) u_stk (.clk(clk), .d(stk0_r), .q(stk_d73));

  always_ff @(posedge clk) begin
    den_sc_r <= new_len;
  end

  // Coulomb check on the trial force
  dtcf_norm u_fn (.clk(clk), .a(f_r[0]), .b(f_r[1]), .c(f_r[2]), .len(fn));
  dtcf_dly #(.W(UW), .N(T_FN)) u_lim (.clk(clk), .d(lim0_r), .q(lim_d110));

  always_ff @(posedge clk) begin
    den_f_r   <= fn;
    slip_r    <= fn > {1'b0, lim_d110};
    slip145_r <= slip_d144;
    stick_r   <= !slip_d179;
  end

  dtcf_dly #(.W(1), .N(DIV_LAT)) u_sl1 (.clk(clk), .d(slip_r), .q(slip_d144));
  dtcf_dly #(.W(1), .N(T_GS - T_F2)) u_sl2 (.clk(clk), .d(slip145_r), .q(slip_d179));

  for (genvar c = 0; c < 3; c++) begin : g_lane
    s18_t n_d2;
    s32_t g0_d3, g1_d38, g1_d72, v_d40, f_d110, f_d144, g3_d179, f2_d179;
    logic signed [PW-1:0] dtv_r, dtv_d73, pd_r, pd_d75, pk_r, dv_r, dv_d145, num_r;
    logic signed [49:0] pq_r;
    logic [PW-1:0] sp_r, fp_r, num_mag;
    logic [QW-1:0] qg, qf, qn;
    logic vneg_d145, num_neg_d179, num_zero_d179;

    dtcf_dly #(.W(NW), .N(2)) u_n (.clk(clk), .d(n0_r[c]), .q(n_d2));
    dtcf_dly #(.W(DW), .N(3)) u_g0 (.clk(clk), .d(g0_r[c]), .q(g0_d3));

    always_ff @(posedge clk) begin
      pn_r[c] <= 50'(n0_r[c]) * 50'(g0_r[c]);
      dtv_r   <= (PW'($signed({1'b0, dt_r})) * PW'(v0_r[c])) >>> FRAC_BITS;
      pq_r    <= 50'(dot_r) * 50'(n_d2);
      g1_r[c] <= sat32(PW'(g0_d3) - (PW'(pq_r) >>> FRAC_BITS));
    end

    // rescale to the old length
    dtcf_dly #(.W(DW), .N(NORM_LAT)) u_g1a (.clk(clk), .d(g1_r[c]), .q(g1_d38));
    dtcf_dly #(.W(DW), .N(T_G2 - 1 - T_G1)) u_g1b (.clk(clk), .d(g1_r[c]), .q(g1_d72));

    always_ff @(posedge clk) begin
      sp_r <= PW'(mag32(g1_d38)) * PW'(old_len_d38);
    end

    dtcf_div u_divg (.clk(clk), .num(sp_r), .den(den_sc_r), .quo(qg));

    dtcf_dly #(.W(PW), .N(T_G2 - 1)) u_dtv (.clk(clk), .d(dtv_r), .q(dtv_d73));

    always_ff @(posedge clk) begin
      g2_r[c] <= nz_d72 ? clip_q(qg, g1_d72[DW-1]) : g1_d72;
      g3_r[c] <= stk_d73 ? sat32(PW'(g2_r[c]) + dtv_d73) : g2_r[c];
    end

    // spring and dashpot
    dtcf_dly #(.W(DW), .N(T_D)) u_v (.clk(clk), .d(v0_r[c]), .q(v_d40));

    always_ff @(posedge clk) begin
      pd_r <= (PW'($signed({1'b0, d_d40})) * PW'(v_d40)) >>> FRAC_BITS;
      dv_r <= $signed(PW'(d_d40) * PW'(mag32(v_d40)));
      pk_r <= (PW'($signed({1'b0, k_r})) * PW'(g3_r[c])) >>> FRAC_BITS;
      f_r[c] <= sat32(-pk_r - pd_d75);
    end

    dtcf_dly #(.W(PW), .N(T_F - 1 - T_PD)) u_pd (.clk(clk), .d(pd_r), .q(pd_d75));

    // clip to the friction limit
    dtcf_dly #(.W(DW), .N(NORM_LAT)) u_fa (.clk(clk), .d(f_r[c]), .q(f_d110));
    dtcf_dly #(.W(DW), .N(T_F2 - 1 - T_F)) u_fb (.clk(clk), .d(f_r[c]), .q(f_d144));

    always_ff @(posedge clk) begin
      fp_r <= PW'(mag32(f_d110)) * PW'(lim_d110);
    end

    dtcf_div u_divf (.clk(clk), .num(fp_r), .den(den_f_r), .quo(qf));

    // gap that matches the clipped force
    dtcf_dly #(.W(PW), .N(T_F2 - T_PD)) u_dv (.clk(clk), .d(dv_r), .q(dv_d145));
    dtcf_dly #(.W(1), .N(T_F2 - T_D)) u_vs (.clk(clk), .d(v_d40[DW-1]), .q(vneg_d145));

    always_ff @(posedge clk) begin
      f2_r[c] <= slip_d144 ? clip_q(qf, f_d144[DW-1]) : f_d144;
      num_r   <= (PW'(f2_r[c]) <<< FRAC_BITS) + (vneg_d145 ? -dv_d145 : dv_d145);
    end

    assign num_mag = num_r[PW-1] ? PW'(-num_r) : PW'(num_r);

    dtcf_div u_divn (.clk(clk), .num(num_mag), .den({1'b0, k_r}), .quo(qn));

    dtcf_dly #(.W(2), .N(DIV_LAT)) u_ns (
      .clk (clk),
      .d   ({num_r[PW-1], num_r == '0}),
      .q   ({num_neg_d179, num_zero_d179})
    );
    dtcf_dly #(.W(DW), .N(T_GS - T_G3)) u_g3 (.clk(clk), .d(g3_r[c]), .q(g3_d179));
    dtcf_dly #(.W(DW), .N(T_GS - T_F2)) u_f2 (.clk(clk), .d(f2_r[c]), .q(f2_d179));

    always_ff @(posedge clk) begin
      frc_r[c] <= f2_d179;
      if (!slip_d179) gap_r[c] <= g3_d179;
      else if (k_r == '0) begin
        if (num_zero_d179) gap_r[c] <= '0;
        else if (num_neg_d179) gap_r[c] <= 32'sh7fff_ffff;
        else gap_r[c] <= 32'sh8000_0000;
      end else gap_r[c] <= clip_q(qn, !num_neg_d179);
    end
  end

  assign out_strobe    = vld_r[T_OUT];
  assign out_force_x   = frc_r[0];
  assign out_force_y   = frc_r[1];
  assign out_force_z   = frc_r[2];
  assign out_new_gap_x = gap_r[0];
  assign out_new_gap_y = gap_r[1];
  assign out_new_gap_z = gap_r[2];
  assign out_stick_out = stick_r;

  a_strobe_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, T_OUT + 1))
    else $error("result strobe without a matching item");

  a_slip_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[T_FP] && slip_r |-> den_f_r != '0)
    else $error("force clip divides by zero norm");

  a_zero_proj: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[T_G2 - 1] && !nz_d72 |=>
      g2_r[0] == '0 && g2_r[1] == '0 && g2_r[2] == '0)
    else $error("zero projected length with nonzero gap");

endmodule
